### hw/rtl/crt_pkg.sv
// Package for the compare/rollover timer register block.
// Request kinds, register word indexes, control bit positions and reset values.
// No dependencies.
package crt_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned FLAG_W   = 6;
   localparam int unsigned PRESC_W  = 16;
   localparam int unsigned PCOUNT_W = 12;
   localparam int unsigned NUM_CMP  = 3;

   // stream packing: req tdata = {write_data, reg_index}, rsp tdata = {irq_line, read_data}
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_kind_type;

   localparam logic [INDEX_W-1:0] REG_CONTROL  = 4'd0;
   localparam logic [INDEX_W-1:0] REG_PRESCALE = 4'd1;
   localparam logic [INDEX_W-1:0] REG_STATUS   = 4'd2;
   localparam logic [INDEX_W-1:0] REG_IRQ_EN   = 4'd3;
   localparam logic [INDEX_W-1:0] REG_CMP1     = 4'd4;
   localparam logic [INDEX_W-1:0] REG_CMP2     = 4'd5;
   localparam logic [INDEX_W-1:0] REG_CMP3     = 4'd6;
   localparam logic [INDEX_W-1:0] REG_CAPT1    = 4'd7;
   localparam logic [INDEX_W-1:0] REG_CAPT2    = 4'd8;
   localparam logic [INDEX_W-1:0] REG_COUNTER  = 4'd9;

   // control bit positions
   localparam int unsigned EN     = 0;
   localparam int unsigned ENMOD  = 1;
   localparam int unsigned CLKSRC = 6;
   localparam int unsigned FRR    = 9;
   localparam int unsigned SWR    = 15;

   // status / irq enable bit positions
   localparam int unsigned ROV     = 5;
   localparam int unsigned CAPT1_F = 3;
   localparam int unsigned CAPT2_F = 4;

   localparam logic [DATA_W-1:0] KEEP_ON_SWR = 32'h0000_003F;
   localparam logic [DATA_W-1:0] CMP_RESET   = '1;

endpackage

### hw/rtl/compare_rollover_timer_regs_unit.sv
// Top level of the compare/rollover timer register block.
// Input register, single-pass register/counter update, result register.
// Depends on crt_pkg.
//
// Each word on the request stream is one timer tick or one register read/write;
// each produces exactly one response word carrying read data (zero for ticks and
// writes) and the interrupt line as seen after that word's update. The block takes
// one word per cycle while the response side keeps up; each word passes the request
// register, then the result register loaded by one pass of the register/counter
// update logic: a 32-bit increment followed by three 32-bit compares. A response
// stall holds the result register; once the request register also holds a word,
// req_tready drops until the response word is taken.
module compare_rollover_timer_regs_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] reg_index, [35:4] write_data, [39:36] zero
   input  logic [crt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [crt_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] read_data, [32] irq_line, [39:33] zero
   output logic [crt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import crt_pkg::*;

   // request register
   logic                 in_valid_ff;
   logic [1:0]           req_kind_ff;
   logic [INDEX_W-1:0]   reg_index_ff;
   logic [DATA_W-1:0]    write_data_ff;

   // result register
   logic                 out_valid_ff;
   logic [DATA_W-1:0]    read_data_ff, read_data_in;
   logic                 irq_ff, irq_in;

   // timer state
   logic [DATA_W-1:0]    control_ff, control_in;
   logic [PRESC_W-1:0]   prescale_ff, prescale_in;
   logic [PCOUNT_W-1:0]  pcount_ff, pcount_in;
   logic [DATA_W-1:0]    count_ff, count_in;
   logic [FLAG_W-1:0]    status_ff, status_in;
   logic [FLAG_W-1:0]    irq_en_ff, irq_en_in;
   logic [DATA_W-1:0]    cmp_ff [NUM_CMP];
   logic [DATA_W-1:0]    cmp_in [NUM_CMP];

   logic                 advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DATA_W-1){1'b0}}, irq_ff, read_data_ff};

   always_comb begin
      logic [DATA_W-1:0] wd;
      logic              ticking;
      logic              count_step;
      wd           = write_data_ff;
      control_in   = control_ff;
      prescale_in  = prescale_ff;
      pcount_in    = pcount_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      irq_en_in    = irq_en_ff;
      for (int k = 0; k < NUM_CMP; k++) begin
         cmp_in[k] = cmp_ff[k];
      end
      read_data_in = '0;
      count_step   = 1'b0;
      ticking      = control_ff[EN] && (control_ff[CLKSRC+2:CLKSRC] != 3'd0);

      case (req_kind_ff)
         REQ_TICK: begin
            if (ticking) begin
               if (pcount_ff == prescale_ff[PCOUNT_W-1:0]) begin
                  pcount_in  = '0;
                  count_step = 1'b1;
               end else begin
                  pcount_in = pcount_ff + PCOUNT_W'(1);
               end
            end
         end
         REQ_READ: begin
            unique case (reg_index_ff)
               REG_CONTROL:  read_data_in = control_ff;
               REG_PRESCALE: read_data_in = DATA_W'(prescale_ff);
               REG_STATUS:   read_data_in = DATA_W'(status_ff);
               REG_IRQ_EN:   read_data_in = DATA_W'(irq_en_ff);
               REG_CMP1:     read_data_in = cmp_ff[0];
               REG_CMP2:     read_data_in = cmp_ff[1];
               REG_CMP3:     read_data_in = cmp_ff[2];
               REG_COUNTER:  read_data_in = count_ff;
               default:      read_data_in = '0;
            endcase
         end
         REQ_WRITE: begin
            unique case (reg_index_ff)
               REG_CONTROL: begin
                  if (wd[SWR]) begin
                     // soft reset keeps bits 5:0 of the written word only
                     prescale_in = '0;
                     pcount_in   = '0;
                     count_in    = '0;
                     status_in   = '0;
                     irq_en_in   = '0;
                     for (int k = 0; k < NUM_CMP; k++) begin
                        cmp_in[k] = CMP_RESET;
                     end
                     control_in = wd & KEEP_ON_SWR;
                  end else begin
                     if (!control_ff[EN] && wd[EN] && wd[ENMOD]) begin
                        pcount_in = '0;
                        count_in  = '0;
                     end
                     control_in      = wd;
                     control_in[SWR] = 1'b0;
                  end
               end
               REG_PRESCALE: prescale_in = wd[PRESC_W-1:0];
               REG_STATUS:   status_in   = status_ff & ~wd[FLAG_W-1:0];
               REG_IRQ_EN:   irq_en_in   = wd[FLAG_W-1:0];
               REG_CMP1:     cmp_in[0]   = wd;
               REG_CMP2:     cmp_in[1]   = wd;
               REG_CMP3:     cmp_in[2]   = wd;
               default: ;
            endcase
         end
         default: ;
      endcase

      if (count_step) begin
         if (!control_ff[FRR] && (count_ff == cmp_ff[0])) begin
            count_in = '0;
         end else begin
            count_in = count_ff + DATA_W'(1);
            if (count_ff == '1) begin
               status_in[ROV] = 1'b1;
            end
         end
         for (int k = 0; k < NUM_CMP; k++) begin
            if (count_in == cmp_ff[k]) begin
               status_in[k] = 1'b1;
            end
         end
      end

      irq_in = |(status_in & irq_en_in);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_kind_ff   <= req_tuser;
         reg_index_ff  <= req_tdata[INDEX_W-1:0];
         write_data_ff <= req_tdata[INDEX_W+DATA_W-1:INDEX_W];
      end
      if (advance) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
      end
   end

   // timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= '0;
         prescale_ff <= '0;
         pcount_ff   <= '0;
         count_ff    <= '0;
         status_ff   <= '0;
         irq_en_ff   <= '0;
         for (int k = 0; k < NUM_CMP; k++) begin
            cmp_ff[k] <= CMP_RESET;
         end
      end else if (advance) begin
         control_ff  <= control_in;
         prescale_ff <= prescale_in;
         pcount_ff   <= pcount_in;
         count_ff    <= count_in;
         status_ff   <= status_in;
         irq_en_ff   <= irq_en_in;
         for (int k = 0; k < NUM_CMP; k++) begin
            cmp_ff[k] <= cmp_in[k];
         end
      end
   end

   // capture flags have no source
   a_no_capture_flags: assert property (@(posedge clock) disable iff (reset)
      !status_ff[CAPT1_F] && !status_ff[CAPT2_F])
      else $error("capture status flag set");

   a_swr_self_clear: assert property (@(posedge clock) disable iff (reset)
      !control_ff[SWR])
      else $error("soft reset bit stored");

   a_irq_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_tdata[DATA_W] == |(status_ff & irq_en_ff)))
      else $error("irq_line does not match updated status");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff) && $stable(status_ff))
      else $error("timer state changed without a word");

endmodule

### tb/crt_rsp_checker.sv
`timescale 1ns / 1ps
// Response checker for the compare/rollover timer register block.
// Keeps its own copy of the timer registers, predicts each response word and compares.
// Depends on crt_pkg.
module crt_rsp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // [3:0] reg_index, [35:4] write_data, [39:36] zero
   input  logic [crt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [crt_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] read_data, [32] irq_line, [39:33] zero
   input  logic [crt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output int unsigned                      fail_count,
   output int unsigned                      words_due
);
   import crt_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_line;
   } timer_rsp_type;

   logic [DATA_W-1:0]   ctrl_q;
   logic [PRESC_W-1:0]  presc_q;
   logic [PCOUNT_W-1:0] presc_cnt_q;
   logic [DATA_W-1:0]   count_q;
   logic [FLAG_W-1:0]   status_q;
   logic [FLAG_W-1:0]   irq_en_q;
   logic [DATA_W-1:0]   cmp_q [NUM_CMP];

   timer_rsp_type due_rsp_q [$];
   int unsigned   fails = 0;

   // everything but the control word; shared by reset and soft reset
   task automatic clear_timer_regs();
      presc_q     = '0;
      presc_cnt_q = '0;
      count_q     = '0;
      status_q    = '0;
      irq_en_q    = '0;
      for (int k = 0; k < NUM_CMP; k++) cmp_q[k] = CMP_RESET;
   endtask

   task automatic apply_timer_word(input logic [1:0] kind, input logic [INDEX_W-1:0] idx,
                                   input logic [DATA_W-1:0] data, output timer_rsp_type rsp);
      rsp.read_data = '0;
      case (kind)
         REQ_TICK: begin
            if (ctrl_q[EN] && ctrl_q[CLKSRC +: 3] != 3'd0) begin
               if (presc_cnt_q == presc_q[PCOUNT_W-1:0]) begin
                  presc_cnt_q = '0;
                  // restart mode returns to zero on the advance after a compare 1 match
                  if (!ctrl_q[FRR] && count_q == cmp_q[0]) begin
                     count_q = '0;
                  end else begin
                     count_q = count_q + 1'b1;
                     if (count_q == '0) status_q[ROV] = 1'b1;
                  end
                  for (int k = 0; k < NUM_CMP; k++)
                     if (count_q == cmp_q[k]) status_q[k] = 1'b1;
               end else begin
                  presc_cnt_q = presc_cnt_q + 1'b1;
               end
            end
         end
         REQ_READ: begin
            case (idx)
               REG_CONTROL:  rsp.read_data = ctrl_q;
               REG_PRESCALE: rsp.read_data = {{(DATA_W-PRESC_W){1'b0}}, presc_q};
               REG_STATUS:   rsp.read_data = {{(DATA_W-FLAG_W){1'b0}}, status_q};
               REG_IRQ_EN:   rsp.read_data = {{(DATA_W-FLAG_W){1'b0}}, irq_en_q};
               REG_CMP1:     rsp.read_data = cmp_q[0];
               REG_CMP2:     rsp.read_data = cmp_q[1];
               REG_CMP3:     rsp.read_data = cmp_q[2];
               REG_COUNTER:  rsp.read_data = count_q;
               default:      rsp.read_data = '0;
            endcase
         end
         REQ_WRITE: begin
            case (idx)
               REG_CONTROL: begin
                  if (data[SWR]) begin
                     clear_timer_regs();
                     ctrl_q = data & KEEP_ON_SWR;
                  end else begin
                     // enable edge with ENMOD set starts counting from zero
                     if (!ctrl_q[EN] && data[EN] && data[ENMOD]) begin
                        presc_cnt_q = '0;
                        count_q     = '0;
                     end
                     ctrl_q      = data;
                     ctrl_q[SWR] = 1'b0;
                  end
               end
               REG_PRESCALE: presc_q  = data[PRESC_W-1:0];
               REG_STATUS:   status_q = status_q & ~data[FLAG_W-1:0];
               REG_IRQ_EN:   irq_en_q = data[FLAG_W-1:0];
               REG_CMP1:     cmp_q[0] = data;
               REG_CMP2:     cmp_q[1] = data;
               REG_CMP3:     cmp_q[2] = data;
               default: ;
            endcase
         end
         default: ;
      endcase
      rsp.irq_line = |(status_q & irq_en_q);
   endtask

   always @(posedge clock) begin
      timer_rsp_type want;
      timer_rsp_type got;
      if (reset) begin
         ctrl_q = '0;
         clear_timer_regs();
         due_rsp_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[DATA_W-1:0];
            got.irq_line  = rsp_tdata[DATA_W];
            if (due_rsp_q.size() == 0) begin
               $error("response word with none outstanding: read_data %h irq_line %b",
                      got.read_data, got.irq_line);
               fails++;
            end else begin
               want = due_rsp_q.pop_front();
               if (got.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                  fails++;
               end
               if (got.irq_line !== want.irq_line) begin
                  $error("irq_line: expected %b, got %b", want.irq_line, got.irq_line);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_timer_word(req_tuser, req_tdata[INDEX_W-1:0],
                             req_tdata[INDEX_W +: DATA_W], want);
            due_rsp_q.push_back(want);
         end
      end
      fail_count <= fails;
      words_due  <= due_rsp_q.size();
   end

endmodule

### tb/tb_compare_rollover_timer_regs_unit.sv
`timescale 1ns / 1ps
// Top of the testbench for the compare/rollover timer register block.
// Drives directed and random bus/tick words under varying backpressure; uses crt_rsp_checker.
// Depends on crt_pkg, compare_rollover_timer_regs_unit and crt_rsp_checker.
module tb_compare_rollover_timer_regs_unit;
   import crt_pkg::*;

   localparam logic [1:0]         REQ_UNUSED  = 2'd3;
   localparam logic [INDEX_W-1:0] REG_UNUSED  = 4'd15;
   localparam int unsigned        PHASE_WORDS = 375;
   localparam int unsigned        LONG_HOLD   = 300;
   localparam int unsigned        CYCLE_LIMIT = 200_000;
   localparam logic [DATA_W-1:0]  RUN_RESTART = (32'd1 << EN) | (32'd1 << ENMOD) |
                                                (32'd1 << CLKSRC);
   localparam logic [DATA_W-1:0]  RUN_FREE    = RUN_RESTART | (32'd1 << FRR);

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int unsigned fail_count;
   int unsigned words_due;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned hold_seq      = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;

   always #2 clock = ~clock;

   compare_rollover_timer_regs_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   crt_rsp_checker rsp_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off whenever hold_seq moves
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic [1:0] kind, input logic [INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W-DATA_W-INDEX_W){1'b0}}, data, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      logic [1:0]         kind;
      logic [INDEX_W-1:0] idx;
      logic [DATA_W-1:0]  data;
      int unsigned        roll;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words
      send_word(REQ_READ, REG_CMP1, '0);
      send_word(REQ_READ, REG_UNUSED, '1);
      send_word(REQ_WRITE, REG_PRESCALE, '1);
      send_word(REQ_READ, REG_PRESCALE, '0);
      send_word(REQ_WRITE, REG_PRESCALE, '0);
      send_word(REQ_WRITE, REG_CMP1, 32'd2);
      send_word(REQ_WRITE, REG_CMP2, 32'd1);
      send_word(REQ_WRITE, REG_CMP3, 32'd0);
      send_word(REQ_WRITE, REG_IRQ_EN, '1);
      send_word(REQ_WRITE, REG_CONTROL, RUN_RESTART);
      // hits compare 2, then compare 1, restarts onto compare 3 at zero
      repeat (4) send_word(REQ_TICK, REG_CONTROL, '1);
      send_word(REQ_READ, REG_STATUS, '0);
      send_word(REQ_WRITE, REG_STATUS, 32'h0000_0001);
      send_word(REQ_READ, REG_COUNTER, '0);
      send_word(REQ_WRITE, REG_COUNTER, '1);
      send_word(REQ_WRITE, REG_CAPT1, '1);
      send_word(REQ_READ, REG_CAPT2, '0);
      send_word(REQ_UNUSED, REG_CONTROL, '1);
      send_word(REQ_WRITE, REG_CONTROL, RUN_FREE);
      repeat (2) send_word(REQ_TICK, REG_CONTROL, '0);
      send_word(REQ_WRITE, REG_CONTROL, '1);
      send_word(REQ_READ, REG_CONTROL, '0);

      // random words; mostly a running timer with small compares and prescale
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  hold_seq++; end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            roll = $urandom_range(99);
            data = $urandom();
            idx  = 4'($urandom_range(15));
            if (roll < 52) begin
               kind = REQ_TICK;
            end else if (roll < 72) begin
               kind = REQ_READ;
               if ($urandom_range(9) != 0) idx = 4'($urandom_range(9));
            end else if (roll < 96) begin
               kind = REQ_WRITE;
               if ($urandom_range(9) != 0) idx = 4'($urandom_range(6));
               if ($urandom_range(7) != 0) begin
                  case (idx) inside
                     REG_CONTROL: begin
                        data[EN]          = ($urandom_range(4) != 0);
                        data[CLKSRC +: 3] = 3'($urandom_range(7, 1));
                        data[SWR]         = ($urandom_range(19) == 0);
                     end
                     REG_PRESCALE: data = $urandom_range(3);
                     REG_CMP1, REG_CMP2, REG_CMP3: data = $urandom_range(24);
                     default: ;
                  endcase
               end
            end else begin
               kind = REQ_UNUSED;
            end
            send_word(kind, idx, data);
         end
      end
      req_tvalid <= 1'b0;

      while (words_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
